@@ hdl/erm_pkg.sv @@
package erm_pkg;

  localparam int ANGLE_BITS_DEF   = 16;
  localparam int ENTRY_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 14;

  // Internal word: signed Q.30 carried in 34 bits (values stay below about 4).
  localparam int QF = 30;
  localparam int WB = 34;
  localparam int PW = 2 * WB;

  localparam logic signed [WB-1:0] Q_PI      = 34'sd3373259426;
  localparam logic signed [WB-1:0] Q_HALF_PI = 34'sd1686629713;

  typedef struct packed {
    logic [ANGLE_BITS_DEF-1:0] angle_x;
    logic [ANGLE_BITS_DEF-1:0] angle_y;
    logic [ANGLE_BITS_DEF-1:0] angle_z;
  } erm_in_t;

  typedef struct packed {
    logic [ENTRY_BITS_DEF-1:0] m_r0c0;
    logic [ENTRY_BITS_DEF-1:0] m_r0c1;
    logic [ENTRY_BITS_DEF-1:0] m_r0c2;
    logic [ENTRY_BITS_DEF-1:0] m_r1c0;
    logic [ENTRY_BITS_DEF-1:0] m_r1c1;
    logic [ENTRY_BITS_DEF-1:0] m_r1c2;
    logic [ENTRY_BITS_DEF-1:0] m_r2c0;
    logic [ENTRY_BITS_DEF-1:0] m_r2c1;
    logic [ENTRY_BITS_DEF-1:0] m_r2c2;
  } erm_out_t;

  // Arctangent of 2^-i in Q.30.
  function automatic logic signed [WB-1:0] atan_q30(input int i);
    case (i)
      0: atan_q30 = 34'sd843314856;   1: atan_q30 = 34'sd497837829;
      2: atan_q30 = 34'sd263043836;   3: atan_q30 = 34'sd133525158;
      4: atan_q30 = 34'sd67021686;    5: atan_q30 = 34'sd33543515;
      6: atan_q30 = 34'sd16775850;    7: atan_q30 = 34'sd8388437;
      8: atan_q30 = 34'sd4194282;     9: atan_q30 = 34'sd2097149;
      10: atan_q30 = 34'sd1048575;    11: atan_q30 = 34'sd524287;
      12: atan_q30 = 34'sd262143;     13: atan_q30 = 34'sd131071;
      14: atan_q30 = 34'sd65535;      15: atan_q30 = 34'sd32767;
      16: atan_q30 = 34'sd16383;      17: atan_q30 = 34'sd8191;
      18: atan_q30 = 34'sd4095;       19: atan_q30 = 34'sd2047;
      20: atan_q30 = 34'sd1023;       21: atan_q30 = 34'sd511;
      22: atan_q30 = 34'sd255;        23: atan_q30 = 34'sd127;
      24: atan_q30 = 34'sd63;         25: atan_q30 = 34'sd31;
      26: atan_q30 = 34'sd15;         27: atan_q30 = 34'sd7;
      28: atan_q30 = 34'sd3;          29: atan_q30 = 34'sd1;
      default: atan_q30 = '0;
    endcase
  endfunction

  // Square root of the squared CORDIC gain scaled by 2^30, evaluated at elaboration.
  function automatic longint unsigned gain_root(input int steps);
    longint g;
    longint unsigned sq, root, bit_v, rem;
    int n;
    g = 64'sd1 << QF;
    root = 0;
    bit_v = 64'd1 << 62;
    n = (steps > 30) ? 30 : ((steps < 1) ? 1 : steps);
    for (int i = 0; i < n; i++) g = g + (g >>> (2 * i));
    sq = longint'(g) << QF;
    rem = sq;
    while (bit_v > rem) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (rem >= root + bit_v) begin
        rem = rem - (root + bit_v);
        root = (root >> 1) + bit_v;
      end else begin
        root = root >> 1;
      end
      bit_v = bit_v >> 2;
    end
    if (root == 0) root = 1;
    gain_root = root;
  endfunction

  // Q.30 product with round half up: floor((a*b + 2^29) / 2^30).
  function automatic logic signed [WB-1:0] mulq(input logic signed [WB-1:0] a,
                                               input logic signed [WB-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b) + (PW'(1) <<< (QF - 1));
    mulq = WB'(p >>> QF);
  endfunction

endpackage

@@ hdl/erm_cordic.sv @@
// One sine/cosine lane: fold, pipelined CORDIC, gain correction, sign fix.
module erm_cordic
  import erm_pkg::*;
#(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output logic signed [WB-1:0]         sin_q,
  output logic signed [WB-1:0]         cos_q
);

  localparam int NS = (CORDIC_STEPS > 30) ? 30 : ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
  // Inverse gain in Q.30: round(2^60 / root).
  localparam longint unsigned G_ROOT = gain_root(CORDIC_STEPS);
  localparam logic signed [WB-1:0] K_INV =
    WB'(((64'd1 << 60) + (G_ROOT >> 1)) / G_ROOT);

  logic signed [WB-1:0] xs [NS+1];
  logic signed [WB-1:0] ys [NS+1];
  logic signed [WB-1:0] zs [NS+1];
  logic                 ng [NS+1];
  logic signed [WB-1:0] z_wide;
  logic signed [WB-1:0] cos_k;
  logic signed [WB-1:0] sin_k;
  logic                 neg_k;

  // Widen the angle to Q.30 and fold it into plus or minus pi/2.
  assign z_wide = WB'(angle) <<< (33 - ANGLE_BITS);

  always_ff @(posedge clk) begin
    xs[0] <= WB'(64'sd1 << QF);
    ys[0] <= '0;
    if (z_wide > Q_HALF_PI) begin
      zs[0] <= z_wide - Q_PI;
      ng[0] <= 1'b1;
    end else if (z_wide < -Q_HALF_PI) begin
      zs[0] <= z_wide + Q_PI;
      ng[0] <= 1'b1;
    end else begin
      zs[0] <= z_wide;
      ng[0] <= 1'b0;
    end
  end

  // One registered micro-rotation per stage.
  for (genvar i = 0; i < NS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!zs[i][WB-1]) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - atan_q30(i);
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + atan_q30(i);
      end
      ng[i+1] <= ng[i];
    end
  end

  // Gain correction, then the fold's sign.
  always_ff @(posedge clk) begin
    cos_k <= mulq(xs[NS], K_INV);
    sin_k <= mulq(ys[NS], K_INV);
    neg_k <= ng[NS];
    cos_q <= neg_k ? -cos_k : cos_k;
    sin_q <= neg_k ? -sin_k : sin_k;
  end

endmodule

@@ hdl/erm_merge.sv @@
// Combines the three lanes' sines and cosines into the nine matrix entries.
module erm_merge
  import erm_pkg::*;
#(
  parameter int ENTRY_BITS = ENTRY_BITS_DEF
) (
  input  logic                         clk,
  input  logic signed [WB-1:0]         sx,
  input  logic signed [WB-1:0]         cx,
  input  logic signed [WB-1:0]         sy,
  input  logic signed [WB-1:0]         cy,
  input  logic signed [WB-1:0]         sz,
  input  logic signed [WB-1:0]         cz,
  output logic signed [ENTRY_BITS-1:0] ent [9]
);

  localparam int SH = 32 - ENTRY_BITS;
  localparam logic signed [WB:0] LIM = (WB+1)'(64'sd1 << (ENTRY_BITS - 2));

  logic signed [WB-1:0] czsy, szsy, sx1, cx1, sy1, cy1, sz1, cz1;
  logic signed [WB-1:0] p [14];
  logic signed [WB:0]   v [9];

  function automatic logic signed [ENTRY_BITS-1:0] to_entry(input logic signed [WB:0] a);
    logic signed [WB:0] r;
    if (SH > 0) r = (a + ((WB+1)'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
    else r = a;
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    to_entry = ENTRY_BITS'(r);
  endfunction

  // Stage 1: shared partial products.
  always_ff @(posedge clk) begin
    czsy <= mulq(cz, sy);
    szsy <= mulq(sz, sy);
    sx1 <= sx; cx1 <= cx; sy1 <= sy; cy1 <= cy; sz1 <= sz; cz1 <= cz;
  end

  // Stage 2: every product term.
  always_ff @(posedge clk) begin
    p[0]  <= mulq(cz1, cy1);
    p[1]  <= mulq(sz1, cx1);
    p[2]  <= mulq(czsy, sx1);
    p[3]  <= mulq(sz1, sx1);
    p[4]  <= mulq(czsy, cx1);
    p[5]  <= mulq(sz1, cy1);
    p[6]  <= mulq(cz1, cx1);
    p[7]  <= mulq(szsy, sx1);
    p[8]  <= mulq(cz1, sx1);
    p[9]  <= mulq(szsy, cx1);
    p[10] <= sy1;
    p[11] <= mulq(cy1, sx1);
    p[12] <= mulq(cy1, cx1);
    p[13] <= '0;
  end

  // Stage 3: sums in Q.30.
  always_ff @(posedge clk) begin
    v[0] <= (WB+1)'(p[0]);
    v[1] <= (WB+1)'(p[2]) - (WB+1)'(p[1]);
    v[2] <= (WB+1)'(p[3]) + (WB+1)'(p[4]);
    v[3] <= (WB+1)'(p[5]);
    v[4] <= (WB+1)'(p[6]) + (WB+1)'(p[7]);
    v[5] <= (WB+1)'(p[9]) - (WB+1)'(p[8]);
    v[6] <= (WB+1)'(p[13]) - (WB+1)'(p[10]);
    v[7] <= (WB+1)'(p[11]);
    v[8] <= (WB+1)'(p[12]);
  end

  // Stage 4: round and saturate.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) ent[i] <= to_entry(v[i]);
  end

endmodule

@@ hdl/euler_rotation_matrix_top.sv @@
// Z-Y-X Euler rotation matrix (R = Rz * Ry * Rx).
// Input: a beat is taken when start is high and busy is low; busy is held
// low, so a new beat may be given every cycle.
// Each beat carries three angles in signed Q2.13 radians. Three CORDIC lanes
// form sine and cosine of all angles side by side, and a merge pipeline
// multiplies and sums them into nine Q1.14 entries saturated to plus or minus one.
// Output: done pulses for one cycle with the matrix on result.
// Pipeline: one fold stage, one stage per CORDIC step, two gain stages
// and four merge stages.
// Throughput: one beat per cycle, set by the fully pipelined lanes.
// Reset clears the valid pipeline so no stale done appears; in-flight beats
// are dropped. The receiver cannot stall; each result is shown once.
module euler_rotation_matrix_top
  import erm_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  erm_in_t  operand,
  output logic     busy,
  output logic     done,
  output erm_out_t result
);

  localparam int NS  = (CORDIC_STEPS > 30) ? 30 : ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
  localparam int LAT = NS + 7;

  logic signed [WB-1:0]             sn [3];
  logic signed [WB-1:0]             cs [3];
  logic signed [ENTRY_BITS_DEF-1:0] ent [9];
  logic [LAT-1:0]                   vld;

  assign busy = 1'b0;

  erm_cordic #(.ANGLE_BITS(ANGLE_BITS_DEF), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_x (
    .clk(clk), .angle(operand.angle_x), .sin_q(sn[0]), .cos_q(cs[0]));
  erm_cordic #(.ANGLE_BITS(ANGLE_BITS_DEF), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_y (
    .clk(clk), .angle(operand.angle_y), .sin_q(sn[1]), .cos_q(cs[1]));
  erm_cordic #(.ANGLE_BITS(ANGLE_BITS_DEF), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_z (
    .clk(clk), .angle(operand.angle_z), .sin_q(sn[2]), .cos_q(cs[2]));

  erm_merge #(.ENTRY_BITS(ENTRY_BITS_DEF)) u_merge (
    .clk(clk), .sx(sn[0]), .cx(cs[0]), .sy(sn[1]), .cy(cs[1]),
    .sz(sn[2]), .cz(cs[2]), .ent(ent));

  // Valid bits that follow each beat through the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  assign done = vld[LAT-1];
  assign result = '{m_r0c0: ent[0], m_r0c1: ent[1], m_r0c2: ent[2],
                    m_r1c0: ent[3], m_r1c1: ent[4], m_r1c2: ent[5],
                    m_r2c0: ent[6], m_r2c1: ent[7], m_r2c2: ent[8]};

endmodule

@@ hdl/erm_checker.sv @@
// Port-level checks for the rotation matrix block.
module erm_checker
  import erm_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     busy,
  input logic     done,
  input erm_out_t result
);

  // The block never refuses a beat.
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // No result right after reset.
  a_quiet_after_reset: assert property (@(posedge clk) $fell(rst) |-> !done)
    else $error("done right after reset");

  // The first and last diagonal entries stay within plus or minus one.
  a_diag_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ($signed(result.m_r0c0) <= 16384 && $signed(result.m_r0c0) >= -16384 &&
              $signed(result.m_r2c2) <= 16384 && $signed(result.m_r2c2) >= -16384))
    else $error("entry out of range");

endmodule

bind euler_rotation_matrix_top erm_checker u_erm_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .result(result));

@@ tb/euler_rotation_matrix_top_test.sv @@
module euler_rotation_matrix_top_test;
  import erm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int LATENCY = STEPS + 7;
  localparam longint Q_PI_L = 64'sd3373259426;
  localparam longint Q_HALF_PI_L = 64'sd1686629713;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  erm_in_t operand = '0;
  logic busy;
  logic done;
  erm_out_t result;

  erm_out_t matrix_q[$];
  int fail_count = 0;
  bit idle_gaps = 1'b1;
  longint inv_gain;

  euler_rotation_matrix_top dut (
    .clk(clk), .rst(rst), .start(start), .operand(operand),
    .busy(busy), .done(done), .result(result)
  );

  always #1 clk = ~clk;

  // Floor shift and rounded Q.30 product.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint atan_step(int i);
    longint tbl[30] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63,
      31, 15, 7, 3, 1};
    return tbl[i];
  endfunction

  // Inverse CORDIC gain, found by integer square root.
  function automatic longint calc_inv_gain();
    longint g;
    longint unsigned root, bit_v, rem;
    g = 64'sd1 <<< 30;
    root = 0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < STEPS; i++) g = g + floor_shift(g, 2 * i);
    rem = longint'(g) << 30;
    while (bit_v > rem) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (rem >= root + bit_v) begin
        rem = rem - (root + bit_v);
        root = (root >> 1) + bit_v;
      end else begin
        root = root >> 1;
      end
      bit_v = bit_v >> 2;
    end
    if (root == 0) root = 1;
    return longint'(((64'd1 << 60) + root / 2) / root);
  endfunction

  // Sine and cosine of a Q2.13 angle in Q.30.
  task automatic cordic_sin_cos(input logic [15:0] ang, output longint s,
                                output longint c);
    longint z, x, y, nx;
    bit flip;
    z = longint'($signed(ang)) <<< 17;
    x = 64'sd1 <<< 30;
    y = 0;
    flip = 1'b0;
    if (z > Q_HALF_PI_L) begin
      z = z - Q_PI_L;
      flip = 1'b1;
    end else if (z < -Q_HALF_PI_L) begin
      z = z + Q_PI_L;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z = z - atan_step(i);
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z = z + atan_step(i);
      end
      x = nx;
    end
    c = qmul(x, inv_gain);
    s = qmul(y, inv_gain);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endtask

  // Round half up to Q1.14 and saturate to plus or minus one.
  function automatic logic [15:0] to_q14(longint v);
    longint r;
    r = (v + (64'sd1 <<< 15)) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  task automatic rotation_matrix(input erm_in_t a, output erm_out_t m);
    longint sx, cx, sy, cy, sz, cz, czsy, szsy;
    cordic_sin_cos(a.angle_x, sx, cx);
    cordic_sin_cos(a.angle_y, sy, cy);
    cordic_sin_cos(a.angle_z, sz, cz);
    czsy = qmul(cz, sy);
    szsy = qmul(sz, sy);
    m.m_r0c0 = to_q14(qmul(cz, cy));
    m.m_r0c1 = to_q14(-qmul(sz, cx) + qmul(czsy, sx));
    m.m_r0c2 = to_q14(qmul(sz, sx) + qmul(czsy, cx));
    m.m_r1c0 = to_q14(qmul(sz, cy));
    m.m_r1c1 = to_q14(qmul(cz, cx) + qmul(szsy, sx));
    m.m_r1c2 = to_q14(-qmul(cz, sx) + qmul(szsy, cx));
    m.m_r2c0 = to_q14(-sy);
    m.m_r2c1 = to_q14(qmul(cy, sx));
    m.m_r2c2 = to_q14(qmul(cy, cx));
  endtask

  // Send one beat; with gaps on, a random idle burst may come first.
  task automatic send_angles(input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az);
    erm_in_t a;
    erm_out_t m;
    int gap;
    a.angle_x = ax;
    a.angle_y = ay;
    a.angle_z = az;
    if (idle_gaps && $urandom_range(3) == 0) begin
      gap = $urandom_range(13, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operand <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    rotation_matrix(a, m);
    matrix_q.insert(matrix_q.size(), m);
  endtask

  task automatic end_of_stream();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (matrix_q.size() != 0) @(posedge clk);
  endtask

  // Compare each result beat with the oldest expected matrix.
  task automatic check_field(string name, logic [15:0] exp, logic [15:0] act);
    if (exp !== act) begin
      $error("%s: expected %0d, actual %0d", name, $signed(exp), $signed(act));
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    erm_out_t e;
    if (!rst && done) begin
      if (matrix_q.size() == 0) begin
        $error("result beat with no matrix expected");
        fail_count++;
      end else begin
        e = matrix_q.pop_front();
        check_field("m_r0c0", e.m_r0c0, result.m_r0c0);
        check_field("m_r0c1", e.m_r0c1, result.m_r0c1);
        check_field("m_r0c2", e.m_r0c2, result.m_r0c2);
        check_field("m_r1c0", e.m_r1c0, result.m_r1c0);
        check_field("m_r1c1", e.m_r1c1, result.m_r1c1);
        check_field("m_r1c2", e.m_r1c2, result.m_r1c2);
        check_field("m_r2c0", e.m_r2c0, result.m_r2c0);
        check_field("m_r2c1", e.m_r2c1, result.m_r2c1);
        check_field("m_r2c2", e.m_r2c2, result.m_r2c2);
      end
    end
  end

  function automatic logic [15:0] rand_angle();
    return 16'($signed($urandom_range(51472)) - 25736);
  endfunction

  // Zero, plus and minus pi, quarter turns, and raw field extremes.
  task automatic test_directed_angles();
    logic [15:0] pts[8] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868,
      -16'sd12868, 16'sh7fff, 16'sh8000, 16'sd12869};
    for (int i = 0; i < 8; i++) send_angles(pts[i], 16'd0, 16'd0);
    for (int i = 0; i < 8; i++) send_angles(16'd0, pts[i], pts[7 - i]);
    send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_angles(16'sh8000, 16'sh8000, 16'sh8000);
    send_angles(16'hffff, 16'd1, 16'h5555);
    send_angles(16'haaaa, 16'd12867, -16'sd12869);
    end_of_stream();
  endtask

  // Random angles in range with a few raw patterns mixed in.
  task automatic test_random_angles(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(15) == 0)
        send_angles(16'($urandom), 16'($urandom), 16'($urandom));
      else
        send_angles(rand_angle(), rand_angle(), rand_angle());
    end
    end_of_stream();
  endtask

  // Hold off until all results are back, then resume.
  task automatic test_drain_pause();
    wait_drained();
    test_random_angles(50);
  endtask

  // Back-to-back beats with no idling.
  task automatic test_full_rate();
    idle_gaps = 1'b0;
    test_random_angles(400);
  endtask

  initial begin
    inv_gain = calc_inv_gain();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_angles();
    test_random_angles(1200);
    test_drain_pause();
    test_full_rate();
    wait_drained();
    repeat (LATENCY + 5) @(posedge clk);
    if (fail_count == 0 && matrix_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/erm_pkg.sv
hdl/erm_cordic.sv
hdl/erm_merge.sv
hdl/euler_rotation_matrix_top.sv
hdl/erm_checker.sv
tb/euler_rotation_matrix_top_test.sv
